/* rtl/core/motor_position_pid_core_assert.svh */
// Assertion macros for the motor position PID core checker.
// Depends on nothing; included by the checker file only.
`ifndef MOTOR_POSITION_PID_CORE_ASSERT_SVH
`define MOTOR_POSITION_PID_CORE_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define MPID_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mpid assertion failed");

// Next-cycle implication, masked during reset.
`define MPID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mpid assertion failed");

`endif

/* rtl/core/mpid_pkg.sv */
// Shared types and constants for the motor position PID core.
// No dependencies; imported by every module and interface of the block.
`timescale 1ns / 1ps

package mpid_pkg;

  // Fixed field widths
  localparam int unsigned TARGET_W   = 16;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned SPEED_W    = 9;
  localparam int unsigned GAIN_W     = 15;
  localparam int unsigned LIMIT_W    = 31;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned QUOT_W     = 11;
  localparam int unsigned ERR_W      = 17;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned P_TERM_W   = 32;
  localparam int unsigned I_TERM_W   = 48;
  localparam int unsigned D_TERM_W   = 28;
  localparam int unsigned DIFF_W     = 12;
  localparam int unsigned TOTAL_W    = 50;
  localparam int unsigned GAIN_SHIFT = 7;
  localparam int unsigned DRIVE_W    = TOTAL_W - GAIN_SHIFT;

  // Control constants
  localparam logic signed [TARGET_W-1:0] TARGET_CEIL    = 16'sd225;
  localparam logic [COUNT_W-1:0]         COUNT_PER_STEP = 16'd36;
  localparam logic [QUOT_W-1:0]          POSITION_CEIL  = 11'd1400;
  localparam logic [QUOT_W-1:0]          POSITION_WRAP  = 11'd1;
  localparam logic signed [DRIVE_W-1:0]  DRIVE_LOW      = -43'sd120;
  localparam logic signed [DRIVE_W-1:0]  DRIVE_HIGH     = 43'sd100;
  localparam logic [SPEED_W-1:0]         SPEED_SAT      = 9'd150;
  localparam logic signed [TOTAL_W-1:0]  ROUND_BIAS     = 50'sd127;

  // count / 36 == (count * 58255) >> 21, exact for every 16-bit count
  localparam logic [COUNT_W-1:0] DIV36_MUL   = 16'd58255;
  localparam int unsigned        DIV36_SHIFT = 21;

  // Register reset values
  localparam logic [GAIN_W-1:0]  KP_RESET      = 15'd128;
  localparam logic [GAIN_W-1:0]  KI_RESET      = 15'd0;
  localparam logic [GAIN_W-1:0]  KD_RESET      = 15'd0;
  localparam logic [GAIN_W-1:0]  ERR_LIM_RESET = 15'd254;
  localparam logic [LIMIT_W-1:0] INT_LIM_RESET = 31'd1073741823;
  localparam logic [GAIN_W-1:0]  P_LIM_RESET   = 15'd32767;
  localparam logic [LIMIT_W-1:0] I_LIM_RESET   = 31'd1073741823;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP        = 3'd0,
    CFG_KI        = 3'd1,
    CFG_KD        = 3'd2,
    CFG_ERR_LIMIT = 3'd3,
    CFG_INT_LIMIT = 3'd4,
    CFG_P_LIMIT   = 3'd5,
    CFG_I_LIMIT   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0]  kp_scaled;
    logic [GAIN_W-1:0]  ki_scaled;
    logic [GAIN_W-1:0]  kd_scaled;
    logic [GAIN_W-1:0]  error_limit;
    logic [LIMIT_W-1:0] integral_limit;
    logic [GAIN_W-1:0]  p_term_limit;
    logic [LIMIT_W-1:0] i_term_limit;
  } cfg_t;

  // Item after the position stage
  typedef struct packed {
    logic signed [TARGET_W-1:0] target;
    logic [QUOT_W-1:0]          quot;
    logic                       dir_up;
  } pos_item_t;

  // Item after the term stage
  typedef struct packed {
    logic signed [P_TERM_W-1:0] p_term;
    logic signed [I_TERM_W-1:0] i_term;
    logic signed [D_TERM_W-1:0] d_term;
    logic                       dir_up;
  } term_item_t;

endpackage

/* rtl/core/mpid_if.sv */
// Valid/ready channel interfaces for the motor position PID core.
// Depends on mpid_pkg for field widths.
`timescale 1ns / 1ps

interface mpid_in_if import mpid_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [TARGET_W-1:0] target_position;
  logic [COUNT_W-1:0]         encoder_count;
  logic                       dir_now_up;

  modport source (output valid, target_position, encoder_count, dir_now_up, input ready);
  modport sink   (input valid, target_position, encoder_count, dir_now_up, output ready);
endinterface

interface mpid_out_if import mpid_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] motor_speed;
  logic               dir_next_up;

  modport source (output valid, motor_speed, dir_next_up, input ready);
  modport sink   (input valid, motor_speed, dir_next_up, output ready);
endinterface

interface mpid_cfg_if import mpid_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/mpid_position.sv */
// Input register and encoder-to-position stage: divide the count by 36.
// Depends on mpid_pkg.
`timescale 1ns / 1ps

module mpid_position import mpid_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic signed [TARGET_W-1:0] target_i,
  input  logic [COUNT_W-1:0]         count_i,
  input  logic                       dir_up_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output pos_item_t                  item_o
);

  logic                       in_valid_q;
  logic signed [TARGET_W-1:0] target_q;
  logic [COUNT_W-1:0]         count_q;
  logic                       dir_q;
  logic                       in_ready;
  logic                       pos_valid_q;
  pos_item_t                  pos_q;
  pos_item_t                  pos_d;
  logic                       pos_ready;
  logic [COUNT_W-1:0]         count_adj;
  logic [2*COUNT_W-1:0]       product;

  assign pos_ready = !pos_valid_q || ready_i;
  assign in_ready  = !in_valid_q || pos_ready;
  assign ready_o   = in_ready;
  assign valid_o   = pos_valid_q;
  assign item_o    = pos_q;

  // Force a low count to one step while moving up, then divide by 36
  always_comb begin
    count_adj    = (count_q <= COUNT_PER_STEP && dir_q) ? COUNT_PER_STEP : count_q;
    product      = count_adj * DIV36_MUL;
    pos_d.target = target_q;
    pos_d.quot   = product[DIV36_SHIFT +: QUOT_W];
    pos_d.dir_up = dir_q;
  end

  // Input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= valid_i;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (valid_i && in_ready) begin
      target_q <= target_i;
      count_q  <= count_i;
      dir_q    <= dir_up_i;
    end
  end

  // Position register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_valid_q <= 1'b0;
    end else if (pos_ready) begin
      pos_valid_q <= in_valid_q;
    end
  end

  // Position register payload
  always_ff @(posedge clk_i) begin
    if (in_valid_q && pos_ready) begin
      pos_q <= pos_d;
    end
  end

endmodule

/* rtl/core/mpid_terms.sv */
// PID term stage: error, saturated P, anti-windup I, D on position change.
// Holds the error sum and last position; depends on mpid_pkg.
`timescale 1ns / 1ps

module mpid_terms import mpid_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       valid_i,
  output logic       ready_o,
  input  pos_item_t  item_i,
  output logic       valid_o,
  input  logic       ready_i,
  output term_item_t item_o
);

  logic                       valid_q;
  term_item_t                 term_q;
  term_item_t                 term_d;
  logic                       advance;
  logic signed [SUM_W-1:0]    err_sum_q;
  logic signed [SUM_W-1:0]    err_sum_d;
  logic [QUOT_W-1:0]          last_pos_q;
  logic signed [TARGET_W-1:0] target_c;
  logic [QUOT_W-1:0]          pos;
  logic signed [ERR_W-1:0]    err;
  logic signed [ERR_W-1:0]    err_lim;
  logic signed [ERR_W+GAIN_W:0] p_prod;
  logic signed [SUM_W:0]      sum_next;
  logic signed [SUM_W:0]      int_lim;
  logic signed [SUM_W:0]      int_lim_neg;
  logic signed [SUM_W+GAIN_W+1:0] i_prod;
  logic signed [DIFF_W-1:0]   pos_diff;
  logic signed [D_TERM_W-1:0] d_prod;

  assign ready_o = !valid_q || ready_i;
  assign advance = valid_i && ready_o;
  assign valid_o = valid_q;
  assign item_o  = term_q;

  always_comb begin
    // Clamp target, fold runaway positions back to one step
    target_c = (item_i.target > TARGET_CEIL) ? TARGET_CEIL : item_i.target;
    pos      = (item_i.quot > POSITION_CEIL) ? POSITION_WRAP : item_i.quot;
    err      = {target_c[TARGET_W-1], target_c} - $signed({{(ERR_W-QUOT_W){1'b0}}, pos});

    // Proportional term with saturation
    err_lim = $signed({{(ERR_W-GAIN_W){1'b0}}, cfg_i.error_limit});
    p_prod  = $signed({1'b0, cfg_i.kp_scaled}) * err;
    if (err > err_lim) begin
      term_d.p_term = $signed({{(P_TERM_W-GAIN_W){1'b0}}, cfg_i.p_term_limit});
    end else if (err < -err_lim) begin
      term_d.p_term = -$signed({{(P_TERM_W-GAIN_W){1'b0}}, cfg_i.p_term_limit});
    end else begin
      term_d.p_term = p_prod[P_TERM_W-1:0];
    end

    // Integral term with anti-windup clamp
    sum_next    = {err_sum_q[SUM_W-1], err_sum_q}
                + {{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err};
    int_lim     = $signed({{(SUM_W+1-LIMIT_W){1'b0}}, cfg_i.integral_limit});
    int_lim_neg = -int_lim;
    i_prod      = $signed({1'b0, cfg_i.ki_scaled}) * sum_next;
    if (sum_next > int_lim) begin
      err_sum_d     = int_lim[SUM_W-1:0];
      term_d.i_term = $signed({{(I_TERM_W-LIMIT_W){1'b0}}, cfg_i.i_term_limit});
    end else if (sum_next < int_lim_neg) begin
      err_sum_d     = int_lim_neg[SUM_W-1:0];
      term_d.i_term = -$signed({{(I_TERM_W-LIMIT_W){1'b0}}, cfg_i.i_term_limit});
    end else begin
      err_sum_d     = sum_next[SUM_W-1:0];
      term_d.i_term = i_prod[I_TERM_W-1:0];
    end

    // Derivative term on the change in position
    pos_diff      = $signed({1'b0, last_pos_q}) - $signed({1'b0, pos});
    d_prod        = $signed({1'b0, cfg_i.kd_scaled}) * pos_diff;
    term_d.d_term = d_prod;
    term_d.dir_up = item_i.dir_up;
  end

  // Controller state advances once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      err_sum_q  <= '0;
      last_pos_q <= '0;
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (advance) begin
        err_sum_q  <= err_sum_d;
        last_pos_q <= pos;
      end
    end
  end

  // Term register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      term_q <= term_d;
    end
  end

endmodule

/* rtl/core/mpid_drive_map.sv */
// Output stage: sum the terms, divide by 128 toward zero, map to speed.
// Result register; depends on mpid_pkg.
`timescale 1ns / 1ps

module mpid_drive_map import mpid_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  term_item_t         item_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [SPEED_W-1:0] speed_o,
  output logic               dir_up_o
);

  logic                      valid_q;
  logic [SPEED_W-1:0]        speed_q;
  logic [SPEED_W-1:0]        speed_d;
  logic                      dir_q;
  logic                      dir_d;
  logic signed [TOTAL_W-1:0] total;
  logic signed [TOTAL_W-1:0] total_adj;
  logic signed [DRIVE_W-1:0] drive;
  logic signed [DRIVE_W-1:0] drive_mag;
  logic [SPEED_W-1:0]        mag;

  assign ready_o  = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign speed_o  = speed_q;
  assign dir_up_o = dir_q;

  always_comb begin
    // Sum and truncate toward zero
    total = {{(TOTAL_W-P_TERM_W){item_i.p_term[P_TERM_W-1]}}, item_i.p_term}
          + {{(TOTAL_W-I_TERM_W){item_i.i_term[I_TERM_W-1]}}, item_i.i_term}
          + {{(TOTAL_W-D_TERM_W){item_i.d_term[D_TERM_W-1]}}, item_i.d_term};
    total_adj = total[TOTAL_W-1] ? (total + ROUND_BIAS) : total;
    drive     = total_adj[TOTAL_W-1:GAIN_SHIFT];
    drive_mag = drive[DRIVE_W-1] ? -drive : drive;
    mag       = drive_mag[SPEED_W-1:0];

    // Map drive to speed and direction
    if (drive < DRIVE_LOW) begin
      speed_d = SPEED_SAT;
      dir_d   = 1'b1;
    end else if (drive > DRIVE_HIGH) begin
      speed_d = SPEED_SAT;
      dir_d   = 1'b0;
    end else if (drive > 0) begin
      speed_d = (mag << 1) + mag;
      dir_d   = 1'b0;
    end else if (drive < 0) begin
      speed_d = (mag << 1) + mag;
      dir_d   = 1'b1;
    end else begin
      speed_d = '0;
      dir_d   = item_i.dir_up;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      speed_q <= speed_d;
      dir_q   <= dir_d;
    end
  end

endmodule

/* rtl/core/motor_position_pid_core.sv */
// Top level of the motor position PID core: configuration registers and stages.
// Depends on mpid_pkg, mpid_if, mpid_position, mpid_terms, mpid_drive_map.
//
// Usage:
//   in_i   carries one control tick per item: target position, raw encoder
//          count and present direction.
//   out_o  returns one item per tick: motor speed and next direction.
//   cfg_i  writes a gain or limit register by index; always ready. Write only
//          while no item is in flight.
//   The input register loads on acceptance, then the position, term and
//   result registers load in turn before output valid rises.
//   Throughput is one item per cycle while the receiver keeps ready high;
//   the error-sum update in the term stage does not hold the flow.
//   Reset clears all stage valids, the error sum and the last position, and
//   loads the register defaults.
//   When the receiver stalls, the result register holds its item and the
//   stages behind it keep filling; in_i drops ready only once all are full.
`timescale 1ns / 1ps

module motor_position_pid_core import mpid_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  mpid_in_if.sink     in_i,
  mpid_out_if.source  out_o,
  mpid_cfg_if.sink    cfg_i
);

  cfg_t       cfg_q;
  logic       pos_valid;
  logic       pos_ready;
  pos_item_t  pos_item;
  logic       term_valid;
  logic       term_ready;
  term_item_t term_item;

  assign cfg_i.ready = 1'b1;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp_scaled      <= KP_RESET;
      cfg_q.ki_scaled      <= KI_RESET;
      cfg_q.kd_scaled      <= KD_RESET;
      cfg_q.error_limit    <= ERR_LIM_RESET;
      cfg_q.integral_limit <= INT_LIM_RESET;
      cfg_q.p_term_limit   <= P_LIM_RESET;
      cfg_q.i_term_limit   <= I_LIM_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_KP:        cfg_q.kp_scaled      <= cfg_i.data[GAIN_W-1:0];
        CFG_KI:        cfg_q.ki_scaled      <= cfg_i.data[GAIN_W-1:0];
        CFG_KD:        cfg_q.kd_scaled      <= cfg_i.data[GAIN_W-1:0];
        CFG_ERR_LIMIT: cfg_q.error_limit    <= cfg_i.data[GAIN_W-1:0];
        CFG_INT_LIMIT: cfg_q.integral_limit <= cfg_i.data[LIMIT_W-1:0];
        CFG_P_LIMIT:   cfg_q.p_term_limit   <= cfg_i.data[GAIN_W-1:0];
        CFG_I_LIMIT:   cfg_q.i_term_limit   <= cfg_i.data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mpid_position u_position (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_i.valid),
    .ready_o  (in_i.ready),
    .target_i (in_i.target_position),
    .count_i  (in_i.encoder_count),
    .dir_up_i (in_i.dir_now_up),
    .valid_o  (pos_valid),
    .ready_i  (pos_ready),
    .item_o   (pos_item)
  );

  mpid_terms u_terms (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (pos_valid),
    .ready_o (pos_ready),
    .item_i  (pos_item),
    .valid_o (term_valid),
    .ready_i (term_ready),
    .item_o  (term_item)
  );

  mpid_drive_map u_drive_map (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (term_valid),
    .ready_o  (term_ready),
    .item_i   (term_item),
    .valid_o  (out_o.valid),
    .ready_i  (out_o.ready),
    .speed_o  (out_o.motor_speed),
    .dir_up_o (out_o.dir_next_up)
  );

endmodule

/* rtl/core/mpid_checker.sv */
// Port-level checker for the motor position PID core, bound to the top level.
// Depends on mpid_pkg and motor_position_pid_core_assert.svh.
`timescale 1ns / 1ps
`include "motor_position_pid_core_assert.svh"

module mpid_checker import mpid_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [SPEED_W-1:0] motor_speed_i,
  input logic               dir_next_up_i,
  input logic               cfg_valid_i,
  input logic               cfg_ready_i
);

  localparam logic [SPEED_W-1:0] SPEED_MAX     = 9'd360;
  localparam logic [SPEED_W-1:0] SPEED_POS_MAX = 9'd300;

  // Stalled result holds until taken
  `MPID_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(motor_speed_i) && $stable(dir_next_up_i))

  // Speed never exceeds the largest mapped magnitude
  `MPID_ASSERT_NOW(a_speed_max, clk_i, rst_ni, out_valid_i, motor_speed_i <= SPEED_MAX)

  // Speeds above the positive range come only from negative drive
  `MPID_ASSERT_NOW(a_high_speed_up, clk_i, rst_ni, out_valid_i && (motor_speed_i > SPEED_POS_MAX), dir_next_up_i)

  // Register writes are never stalled
  `MPID_ASSERT_NOW(a_cfg_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_i)

endmodule

bind motor_position_pid_core mpid_checker u_mpid_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .motor_speed_i (out_o.motor_speed),
  .dir_next_up_i (out_o.dir_next_up),
  .cfg_valid_i   (cfg_i.valid),
  .cfg_ready_i   (cfg_i.ready)
);

/* tb/sv/motor_position_pid_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the motor position PID core: watches the tick, drive and
// register channels, predicts each drive command and compares it field by field.
// Depends on mpid_pkg and the channel interfaces of mpid_if.

module motor_position_pid_checker import mpid_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  mpid_in_if          tick_i,
  mpid_out_if         drive_i,
  mpid_cfg_if         cfg_i,
  output int unsigned mismatch_count_o,
  output int unsigned ticks_in_flight_o
);

  // Control law constants
  localparam longint TARGET_MAX      = 225;
  localparam longint COUNTS_PER_STEP = 36;
  localparam longint POSITION_MAX    = 1400;
  localparam longint POSITION_FOLD   = 1;
  localparam longint DRIVE_FLOOR     = -120;
  localparam longint DRIVE_CEIL      = 100;
  localparam longint SPEED_LIMITED   = 150;
  localparam longint SPEED_GAIN      = 3;
  localparam longint GAIN_DIV        = 128;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic               dir_up;
  } drive_cmd_t;

  cfg_t                       gains;
  logic signed [SUM_W-1:0]    error_sum;
  logic [TARGET_W-1:0]        last_pos;
  drive_cmd_t                 pending_drives[$];
  int unsigned                drive_no;

  // Run one control tick against the shadow state and return its drive command
  function automatic drive_cmd_t predict_drive(input logic signed [TARGET_W-1:0] tgt_in,
                                               input logic [COUNT_W-1:0] cnt_in,
                                               input logic up_now);
    longint     tgt, cnt, pos, err, acc, lim, p_term, i_term, d_term, drive;
    drive_cmd_t cmd;
    tgt = longint'(tgt_in);
    if (tgt > TARGET_MAX) tgt = TARGET_MAX;

    // Coarse position from the encoder, with the low end pinned when moving up
    cnt = longint'(cnt_in);
    if (cnt <= COUNTS_PER_STEP && up_now) cnt = COUNTS_PER_STEP;
    pos = cnt / COUNTS_PER_STEP;
    if (pos > POSITION_MAX) pos = POSITION_FOLD;
    err = tgt - pos;

    // Proportional term, saturated beyond the error limit
    if (err > longint'(gains.error_limit)) begin
      p_term = longint'(gains.p_term_limit);
    end else if (err < -longint'(gains.error_limit)) begin
      p_term = -longint'(gains.p_term_limit);
    end else begin
      p_term = longint'(gains.kp_scaled) * err;
    end

    // Integral term with anti-windup clamp on the error sum
    acc = longint'(error_sum) + err;
    lim = longint'(gains.integral_limit);
    if (acc > lim) begin
      error_sum = SUM_W'(lim);
      i_term = longint'(gains.i_term_limit);
    end else if (acc < -lim) begin
      error_sum = SUM_W'(-lim);
      i_term = -longint'(gains.i_term_limit);
    end else begin
      error_sum = SUM_W'(acc);
      i_term = longint'(gains.ki_scaled) * acc;
    end

    // Derivative term on the change in position
    d_term = longint'(gains.kd_scaled) * (longint'(last_pos) - pos);
    last_pos = TARGET_W'(pos);

    // Map the truncated drive value to speed and direction
    drive = (p_term + i_term + d_term) / GAIN_DIV;
    if (drive < DRIVE_FLOOR) begin
      cmd.speed = SPEED_W'(SPEED_LIMITED);
      cmd.dir_up = 1'b1;
    end else if (drive > DRIVE_CEIL) begin
      cmd.speed = SPEED_W'(SPEED_LIMITED);
      cmd.dir_up = 1'b0;
    end else if (drive > 0) begin
      cmd.speed = SPEED_W'(drive * SPEED_GAIN);
      cmd.dir_up = 1'b0;
    end else if (drive < 0) begin
      cmd.speed = SPEED_W'(-drive * SPEED_GAIN);
      cmd.dir_up = 1'b1;
    end else begin
      cmd.speed = '0;
      cmd.dir_up = up_now;
    end
    return cmd;
  endfunction

  // Track register writes, predict accepted ticks, compare accepted drive items
  always @(posedge clk_i or negedge rst_ni) begin
    drive_cmd_t want;
    if (!rst_ni) begin
      gains.kp_scaled      = KP_RESET;
      gains.ki_scaled      = KI_RESET;
      gains.kd_scaled      = KD_RESET;
      gains.error_limit    = ERR_LIM_RESET;
      gains.integral_limit = INT_LIM_RESET;
      gains.p_term_limit   = P_LIM_RESET;
      gains.i_term_limit   = I_LIM_RESET;
      error_sum = '0;
      last_pos = '0;
      pending_drives.delete();
      drive_no = 0;
      mismatch_count_o = 0;
      ticks_in_flight_o = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_KP:        gains.kp_scaled      = cfg_i.data[GAIN_W-1:0];
          CFG_KI:        gains.ki_scaled      = cfg_i.data[GAIN_W-1:0];
          CFG_KD:        gains.kd_scaled      = cfg_i.data[GAIN_W-1:0];
          CFG_ERR_LIMIT: gains.error_limit    = cfg_i.data[GAIN_W-1:0];
          CFG_INT_LIMIT: gains.integral_limit = cfg_i.data[LIMIT_W-1:0];
          CFG_P_LIMIT:   gains.p_term_limit   = cfg_i.data[GAIN_W-1:0];
          CFG_I_LIMIT:   gains.i_term_limit   = cfg_i.data[LIMIT_W-1:0];
          default: ;
        endcase
      end

      if (drive_i.valid && drive_i.ready) begin
        if (pending_drives.size() == 0) begin
          $display("%0t: drive item %0d with none expected: motor_speed %0d dir_next_up %0b",
                   $time, drive_no, drive_i.motor_speed, drive_i.dir_next_up);
          mismatch_count_o++;
        end else begin
          want = pending_drives.pop_front();
          if (drive_i.motor_speed !== want.speed) begin
            $display("%0t: drive item %0d motor_speed expected %0d actual %0d",
                     $time, drive_no, want.speed, drive_i.motor_speed);
            mismatch_count_o++;
          end
          if (drive_i.dir_next_up !== want.dir_up) begin
            $display("%0t: drive item %0d dir_next_up expected %0b actual %0b",
                     $time, drive_no, want.dir_up, drive_i.dir_next_up);
            mismatch_count_o++;
          end
        end
        drive_no++;
      end

      if (tick_i.valid && tick_i.ready) begin
        pending_drives.push_back(predict_drive(tick_i.target_position, tick_i.encoder_count,
                                               tick_i.dir_now_up));
      end
      ticks_in_flight_o = pending_drives.size();
    end
  end

endmodule

/* tb/sv/motor_position_pid_core_tb.sv */
`timescale 1ns / 1ps
// Top of the motor position PID core testbench: clock, reset, tick and register
// stimulus, receiver stalls and the verdict.
// Depends on mpid_pkg, mpid_if, motor_position_pid_core and motor_position_pid_checker.

module motor_position_pid_core_tb import mpid_pkg::*; ();

  localparam int unsigned HALF_PERIOD      = 2;
  localparam int unsigned RESET_CYCLES     = 11;
  localparam int unsigned SETTLE_CYCLES    = 12;
  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam int unsigned TICKS_PER_PHASE  = 60;
  localparam int unsigned PHASE_COUNT      = 10;
  localparam int          STEP_COUNTS      = 36;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef enum int {GAINS_TYPICAL, GAINS_MAX, GAINS_ZERO, GAINS_WILD} gain_mode_e;
  typedef enum int {ACCEPT_ALL, STALL_COIN, STALL_RARE, STALL_PERIODIC, STALL_BLOCK} stall_mode_e;

  typedef struct packed {
    logic signed [TARGET_W-1:0] tgt;
    logic [COUNT_W-1:0]         cnt;
    logic                       up;
  } tick_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned mismatch_count;
  int unsigned ticks_in_flight;
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;

  // Edge cases under the reset gains: zero drive, linear band edges, clamps, folds
  tick_t edge_ticks [18] = '{
    '{16'sd0, 16'd0, 1'b1},          '{16'sd0, 16'd0, 1'b0},
    '{16'sd0, 16'd36, 1'b0},         '{16'sd1, 16'd36, 1'b1},
    '{16'sd5, 16'd35, 1'b1},         '{16'sd5, 16'd37, 1'b1},
    '{16'sd100, 16'd0, 1'b0},        '{16'sd101, 16'd0, 1'b0},
    '{-16'sd120, 16'd0, 1'b1},       '{-16'sd121, 16'd0, 1'b0},
    '{16'sd32767, 16'd0, 1'b1},      '{16'sd226, 16'd8100, 1'b0},
    '{16'sh8000, 16'd65535, 1'b0},   '{16'sd1, 16'd50436, 1'b1},
    '{16'sd0, 16'd50435, 1'b0},      '{-16'sd254, 16'd0, 1'b0},
    '{16'sd21845, 16'd43690, 1'b1},  '{-16'sd21846, 16'd21845, 1'b0}
  };

  // Drive the error sum into both clamps, then make a large position step
  tick_t windup_ticks [7] = '{
    '{16'sd225, 16'd0, 1'b0},        '{16'sd225, 16'd0, 1'b0},
    '{16'sd225, 16'd0, 1'b0},        '{-16'sd2000, 16'd0, 1'b1},
    '{-16'sd2000, 16'd0, 1'b1},      '{16'sd0, 16'd36000, 1'b1},
    '{16'sd0, 16'd0, 1'b1}
  };

  gain_mode_e phase_plan [PHASE_COUNT] = '{
    GAINS_TYPICAL, GAINS_WILD, GAINS_MAX, GAINS_TYPICAL, GAINS_ZERO,
    GAINS_TYPICAL, GAINS_WILD, GAINS_TYPICAL, GAINS_MAX, GAINS_TYPICAL
  };

  mpid_in_if  in_ch ();
  mpid_out_if out_ch ();
  mpid_cfg_if cfg_ch ();

  motor_position_pid_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  motor_position_pid_checker scoreboard (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .tick_i            (in_ch),
    .drive_i           (out_ch),
    .cfg_i             (cfg_ch),
    .mismatch_count_o  (mismatch_count),
    .ticks_in_flight_o (ticks_in_flight)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one tick, inserting a random gap whenever a burst runs out
  task automatic send_tick(input tick_t t);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
      if (gap != 0) begin
        @(negedge clk_i);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
    end
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.target_position <= t.tgt;
    in_ch.encoder_count <= t.cnt;
    in_ch.dir_now_up <= t.up;
    do @(posedge clk_i); while (!in_ch.ready);
    burst_left--;
  endtask

  // Drop valid and hold until every drive item is back and the pipe is empty
  task automatic settle_idle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (ticks_in_flight != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write one register, filling the bits above its width with noise
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value,
                           input int unsigned width);
    logic [CFG_DATA_W-1:0] data;
    data = value;
    if (width < CFG_DATA_W) data = (value & ((32'd1 << width) - 32'd1)) | ($urandom() << width);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  task automatic load_gains(input gain_mode_e mode);
    logic [CFG_DATA_W-1:0] kp, ki, kd, err_lim, int_lim, p_lim, i_lim;
    case (mode)
      GAINS_TYPICAL: begin
        kp = $urandom_range(16, 1024);
        ki = $urandom_range(0, 64);
        kd = $urandom_range(0, 2048);
        err_lim = $urandom_range(0, 600);
        int_lim = $urandom_range(0, 4000);
        p_lim = $urandom_range(0, 32767);
        i_lim = $urandom_range(0, 40000);
      end
      GAINS_MAX: begin
        {kp, ki, kd, err_lim, int_lim, p_lim, i_lim} = '1;
      end
      GAINS_ZERO: begin
        {kp, ki, kd, err_lim, int_lim, p_lim, i_lim} = '0;
      end
      default: begin
        kp = $urandom();
        ki = $urandom();
        kd = $urandom();
        err_lim = $urandom();
        int_lim = $urandom();
        p_lim = $urandom();
        i_lim = $urandom();
      end
    endcase
    write_reg(CFG_KP, kp, GAIN_W);
    write_reg(CFG_KI, ki, GAIN_W);
    write_reg(CFG_KD, kd, GAIN_W);
    write_reg(CFG_ERR_LIMIT, err_lim, GAIN_W);
    write_reg(CFG_INT_LIMIT, int_lim, LIMIT_W);
    write_reg(CFG_P_LIMIT, p_lim, GAIN_W);
    write_reg(CFG_I_LIMIT, i_lim, LIMIT_W);
    write_reg(CFG_UNUSED, $urandom(), CFG_DATA_W);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly track a target near the position; mix in raw counts and full-range noise
  function automatic tick_t random_tick();
    tick_t t;
    int    pos;
    int    kind;
    kind = $urandom_range(0, 9);
    pos = (kind == 6) ? int'($urandom_range(0, 1400)) : int'($urandom_range(0, 260));
    t.cnt = COUNT_W'(pos * STEP_COUNTS + int'($urandom_range(0, STEP_COUNTS - 1)));
    t.tgt = TARGET_W'(pos + int'($urandom_range(0, 300)) - 150);
    t.up = 1'($urandom());
    case (kind)
      7: t.cnt = COUNT_W'($urandom());
      8: begin
        t.tgt = TARGET_W'($urandom());
        t.cnt = COUNT_W'($urandom());
      end
      9: t.cnt = COUNT_W'($urandom_range(0, 40));
      default: ;
    endcase
    return t;
  endfunction

  // Stall the drive channel on a random pattern that changes after each random span
  initial begin : stall_drives
    stall_mode_e mode;
    int unsigned span, step;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = stall_mode_e'($urandom_range(0, 4));
      span = $urandom_range(32, 160);
      for (step = 0; step < span; step++) begin
        @(negedge clk_i);
        case (mode)
          ACCEPT_ALL:     out_ch.ready <= 1'b1;
          STALL_COIN:     out_ch.ready <= 1'($urandom());
          STALL_RARE:     out_ch.ready <= ($urandom_range(0, 7) != 0);
          STALL_PERIODIC: out_ch.ready <= ((step % 11) >= 5);
          default:        out_ch.ready <= ((step % 40) >= 25);
        endcase
      end
    end
  end

  initial begin : run_ticks
    int unsigned phase;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.target_position = '0;
    in_ch.encoder_count = '0;
    in_ch.dir_now_up = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed edges under reset gains
    foreach (edge_ticks[i]) send_tick(edge_ticks[i]);
    settle_idle();

    // Anti-windup and derivative path
    write_reg(CFG_KP, '0, GAIN_W);
    write_reg(CFG_KI, 32'd128, GAIN_W);
    write_reg(CFG_KD, 32'd256, GAIN_W);
    write_reg(CFG_INT_LIMIT, 32'd300, LIMIT_W);
    write_reg(CFG_I_LIMIT, 32'd5000, LIMIT_W);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    foreach (windup_ticks[i]) send_tick(windup_ticks[i]);
    settle_idle();

    // Random phases over a spread of gain settings
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      load_gains(phase_plan[phase]);
      repeat (TICKS_PER_PHASE) send_tick(random_tick());
      settle_idle();
    end

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
